// ===== design/drr_pkg.sv =====
// Shared constants, codes and types of the deficit round-robin scheduler.
// No dependencies; every other design file but drr_ram imports this package.
`default_nettype none

package drr_pkg;

  // Scheduler geometry
  localparam int QUEUES      = 4;
  localparam int MTU         = 1500;
  localparam int QW          = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int NUM_WEIGHTS = 4;

  // Field widths
  localparam int QUEUE_W     = 2;
  localparam int LEN_W       = 16;
  localparam int METRIC_W    = 16;
  localparam int COST_W      = 32;
  localparam int DEF_W       = 32;
  localparam int DEF_W1      = DEF_W + 1;
  localparam int WEIGHT_W    = 8;
  localparam int DIVISOR_W   = 16;
  localparam int QUANTUM_W   = WEIGHT_W + $clog2(MTU + 1);
  localparam int HEAD_W      = LEN_W + COST_W;

  // Queue index limit for a present word
  localparam logic [QUEUE_W:0] QUEUE_LIM = (QUEUE_W + 1)'(QUEUES);

  // Divider: four quotient bits per cycle
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_CYCLES     = COST_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_DIVISOR = 3'd5;

  localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET  = 8'd1;
  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd1500;

  // Input operation codes
  localparam logic OP_PRESENT = 1'b0;
  localparam logic OP_PULL    = 1'b1;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_START = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_READ  = 8'b0000_1000,
    ST_ADD   = 8'b0001_0000,
    ST_EVAL  = 8'b0010_0000,
    ST_FLUSH = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } drr_state_t;

endpackage

`default_nettype wire

// ===== design/drr_if.sv =====
// Valid/ready channel interfaces of the scheduler: request words in,
// result words out. Depends on drr_pkg for the field widths.
`default_nettype none

interface drr_in_if import drr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [QUEUE_W-1:0]  queue;
  logic [LEN_W-1:0]    packet_length;
  logic [METRIC_W-1:0] link_metric;

  modport source (output valid, op, queue, packet_length, link_metric, input ready);
  modport sink   (input valid, op, queue, packet_length, link_metric, output ready);
endinterface

interface drr_out_if import drr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [QUEUE_W-1:0] grant_queue;
  logic [LEN_W-1:0]   grant_length;
  logic               active;
  logic               rejected;

  modport source (output valid, granted, grant_queue, grant_length, active, rejected,
                  input ready);
  modport sink   (input valid, granted, grant_queue, grant_length, active, rejected,
                  output ready);
endinterface

`default_nettype wire

// ===== design/deficit_round_robin_scheduler.sv =====
// Deficit round-robin scheduler over QUEUES single-packet queues.
// Depends on drr_pkg, drr_if, drr_ram and drr_div.
//
// Usage:
//   items   : request words. op = present loads a head packet (length, link
//             metric) into one queue; op = pull asks for the next packet.
//   results : one word per request: grant flag, queue and length of the
//             released packet, an activity flag, and a reject flag for a
//             present to an occupied or nonexistent queue.
//   cfg_*   : write-only registers (weights, metric mode, cost divisor);
//             write only while no request is in flight.
// Timing: one request at a time. A present's result is ready once it is
//   accepted (rejected or length cost), or in metric mode once the iterative
//   divider ends. A pull visits queues in turn, each visit a deficit/head
//   memory read, a quantum add, and a compare and write back, until a grant
//   or a full scan; each visit is one memory read-modify-write.
// Reset: all heads empty, deficits zero, pointer at queue 0, weights 1,
//   cost divisor 1500. Deficits carry per-entry valid flags, so no clearing
//   pass is needed.
// Stall: a finished result sits in the output register; a new request is
//   taken while it waits, and its own result holds until the register frees.
`default_nettype none

module deficit_round_robin_scheduler import drr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  drr_in_if.sink                     items,
  drr_out_if.source                  results
);

  // Configuration registers
  logic [WEIGHT_W-1:0]  weight [NUM_WEIGHTS];
  logic                 metric_mode;
  logic [DIVISOR_W-1:0] cost_divisor;

  // Control state
  drr_state_t      state;
  logic [QUEUES-1:0] head_valid;
  logic [QUEUES-1:0] deficit_valid;
  logic [QW-1:0]   next_queue;
  logic [QW-1:0]   visits;
  logic            pend;
  logic            wrap;
  logic            act;
  logic            out_valid;

  // Payload registers
  logic [QW-1:0]        q_r;
  logic [LEN_W-1:0]     len_r;
  logic [METRIC_W-1:0]  metric_r;
  logic [QUANTUM_W-1:0] quantum;
  logic [DEF_W-1:0]     d_acc;
  logic                 res_granted;
  logic [QUEUE_W-1:0]   res_queue;
  logic [LEN_W-1:0]     res_length;
  logic                 res_active;
  logic                 res_rejected;
  logic                 out_granted;
  logic [QUEUE_W-1:0]   out_queue;
  logic [LEN_W-1:0]     out_length;
  logic                 out_active;
  logic                 out_rejected;

  // Memory ports
  logic              head_we;
  logic [QW-1:0]     head_waddr;
  logic [HEAD_W-1:0] head_wdata;
  logic [HEAD_W-1:0] head_rdata;
  logic              def_we;
  logic [DEF_W-1:0]  def_wdata;
  logic [DEF_W-1:0]  def_rdata;
  logic              mem_re;

  // Divider
  logic                 div_start;
  logic                 div_done;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [COST_W-1:0]    div_dividend;
  logic [COST_W-1:0]    div_quotient;

  // Combinational helpers
  logic              accept;
  logic [QW-1:0]     in_qidx;
  logic              q_ok;
  logic              present_ok;
  logic [QW-1:0]     ptr_inc;
  logic [DEF_W-1:0]  d_cur;
  logic [DEF_W:0]    d_sum;
  logic [DEF_W-1:0]  d_sat;
  logic [COST_W-1:0] head_cost;
  logic [LEN_W-1:0]  head_len;
  logic              head_hit;
  logic              out_free;

  assign accept     = items.valid && items.ready;
  assign in_qidx    = items.queue[QW-1:0];
  assign q_ok       = {1'b0, items.queue} < QUEUE_LIM;
  assign present_ok = q_ok && !head_valid[in_qidx];
  assign ptr_inc    = (next_queue == QW'(QUEUES - 1)) ? '0 : next_queue + 1'b1;
  assign out_free   = !out_valid || results.ready;

  // Deficit of the visited queue, with the pending quantum added and saturated
  assign d_cur = deficit_valid[next_queue] ? def_rdata : '0;
  assign d_sum = {1'b0, d_cur} + DEF_W1'(quantum);
  assign d_sat = d_sum[DEF_W] ? {DEF_W{1'b1}} : d_sum[DEF_W-1:0];

  assign head_cost = head_rdata[COST_W-1:0];
  assign head_len  = head_rdata[HEAD_W-1:COST_W];
  assign head_hit  = (state == ST_EVAL) && head_valid[next_queue] && (head_cost <= d_acc);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight[i] <= WEIGHT_RESET;
      end
      metric_mode  <= 1'b0;
      cost_divisor <= DIVISOR_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_WEIGHT_0:     weight[0]    <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_1:     weight[1]    <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_2:     weight[2]    <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_3:     weight[3]    <= cfg_data[WEIGHT_W-1:0];
        CFG_METRIC_MODE:  metric_mode  <= cfg_data[0];
        CFG_COST_DIVISOR: cost_divisor <= cfg_data[DIVISOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Head memory write: plain cost at accept, divided cost when the divider ends
  always_comb begin
    head_we    = 1'b0;
    head_waddr = q_r;
    head_wdata = {len_r, div_quotient};
    if (state == ST_IDLE) begin
      head_we    = accept && (items.op == OP_PRESENT) && present_ok && !metric_mode;
      head_waddr = in_qidx;
      head_wdata = {items.packet_length, COST_W'(items.packet_length)};
    end else if (state == ST_DIV) begin
      head_we = div_done;
    end
  end

  // Deficit write back: cleared, charged, or carried with its new quantum
  always_comb begin
    def_we    = (state == ST_EVAL) || (state == ST_FLUSH);
    def_wdata = d_acc;
    if (state == ST_EVAL) begin
      if (!head_valid[next_queue]) begin
        def_wdata = '0;
      end else if (head_hit) begin
        def_wdata = d_acc - head_cost;
      end
    end
  end

  assign mem_re = (state == ST_READ);

  drr_ram #(.WIDTH(HEAD_W), .DEPTH(QUEUES)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (mem_re),
    .raddr (next_queue),
    .rdata (head_rdata)
  );

  drr_ram #(.WIDTH(DEF_W), .DEPTH(QUEUES)) u_deficit_ram (
    .clk   (clk),
    .we    (def_we),
    .waddr (next_queue),
    .wdata (def_wdata),
    .re    (mem_re),
    .raddr (next_queue),
    .rdata (def_rdata)
  );

  // Metric-mode cost: product registered inside the divider
  assign div_start    = (state == ST_START);
  assign div_dividend = COST_W'(len_r) * COST_W'(metric_r);
  assign div_divisor  = (cost_divisor == '0) ? DIVISOR_W'(1) : cost_divisor;

  drr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer: control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head_valid    <= '0;
      deficit_valid <= '0;
      next_queue    <= '0;
      visits        <= '0;
      pend          <= 1'b0;
      wrap          <= 1'b0;
      act           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (results.ready && !((state == ST_DONE) && out_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (items.op == OP_PRESENT) begin
              if (present_ok && metric_mode) begin
                state <= ST_START;
              end else begin
                if (present_ok) begin
                  head_valid[in_qidx] <= 1'b1;
                end
                state <= ST_DONE;
              end
            end else begin
              visits <= '0;
              pend   <= 1'b0;
              wrap   <= 1'b0;
              act    <= 1'b0;
              state  <= ST_READ;
            end
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            head_valid[q_r] <= 1'b1;
            state           <= ST_DONE;
          end
        end
        ST_READ: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          state <= wrap ? ST_FLUSH : ST_EVAL;
        end
        ST_EVAL: begin
          deficit_valid[next_queue] <= 1'b1;
          act <= act | head_valid[next_queue];
          if (head_hit) begin
            head_valid[next_queue] <= 1'b0;
            state <= ST_DONE;
          end else begin
            next_queue <= ptr_inc;
            pend       <= 1'b1;
            if (visits == QW'(QUEUES - 1)) begin
              wrap <= 1'b1;
            end else begin
              visits <= visits + 1'b1;
            end
            state <= ST_READ;
          end
        end
        ST_FLUSH: begin
          deficit_valid[next_queue] <= 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Sequencer: payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        q_r          <= in_qidx;
        len_r        <= items.packet_length;
        metric_r     <= items.link_metric;
        res_granted  <= 1'b0;
        res_queue    <= '0;
        res_length   <= '0;
        res_active   <= 1'b0;
        res_rejected <= (items.op == OP_PRESENT) && !present_ok;
      end
      ST_READ: begin
        quantum <= QUANTUM_W'(weight[next_queue]) * QUANTUM_W'(MTU);
      end
      ST_ADD: begin
        d_acc <= pend ? d_sat : d_cur;
      end
      ST_EVAL: begin
        if (head_hit) begin
          res_granted <= 1'b1;
          res_queue   <= QUEUE_W'(next_queue);
          res_length  <= head_len;
          res_active  <= 1'b1;
        end
      end
      ST_FLUSH: begin
        res_active <= act;
      end
      ST_DONE: begin
        if (out_free) begin
          out_granted  <= res_granted;
          out_queue    <= res_queue;
          out_length   <= res_length;
          out_active   <= res_active;
          out_rejected <= res_rejected;
        end
      end
      default: ;
    endcase
  end

  assign items.ready          = (state == ST_IDLE);
  assign results.valid        = out_valid;
  assign results.granted      = out_granted;
  assign results.grant_queue  = out_queue;
  assign results.grant_length = out_length;
  assign results.active       = out_active;
  assign results.rejected     = out_rejected;

  // A grant always comes with the activity flag and never with a reject
  a_grant_flags: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.granted |-> results.active && !results.rejected)
    else $error("grant word with inconsistent flags");

  // A granted head is emptied on the next edge
  a_grant_clears: assert property (@(posedge clk) disable iff (rst)
    head_hit |=> !head_valid[$past(next_queue)])
    else $error("granted head still valid");

  // The divider finishes only while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  // The final carry-out write only happens after every queue was visited
  a_flush_wrap: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> wrap && visits == QW'(QUEUES - 1))
    else $error("deficit flush before scan end");

  // A result word is only launched from a finished request
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result launched outside done state");

endmodule

`default_nettype wire

// ===== design/drr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; width and depth come from its parameters.
`default_nettype none

module drr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while not read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/drr_div.sv =====
// Iterative unsigned divider for the metric-mode packet cost.
// Restoring, four quotient bits per cycle; depends on drr_pkg.
`default_nettype none

module drr_div import drr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [COST_W-1:0]    dividend,
  input  wire logic [DIVISOR_W-1:0] divisor,
  output      logic                 done,
  output      logic [COST_W-1:0]    quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [COST_W-1:0]    quo;
  logic [DIVISOR_W-1:0] rem_next;
  logic [COST_W-1:0]    quo_next;
  logic [DIVISOR_W:0]   trial;

  // Four restoring steps: dividend bits leave the top of quo, quotient bits enter below
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int s = 0; s < DIV_RADIX_BITS; s++) begin
      trial    = {rem_next, quo_next[COST_W-1]};
      quo_next = {quo_next[COST_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DIVISOR_W-1:0];
    end
  end

  // Control: count the steps, pulse done with the final quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire
